>>> hw/rtl/tick_timer_event_scheduler_assert.svh
// Assertion macros used by the scheduler datapath.
`ifndef TICK_TIMER_EVENT_SCHEDULER_ASSERT_SVH
`define TICK_TIMER_EVENT_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TTES_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler check failed");
// next-cycle implication
`define TTES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler check failed");
`else
`define TTES_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define TTES_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/ttes_pkg.sv
package ttes_pkg;

    // operation codes
    localparam logic [2:0] OPC_TICK       = 3'd0;
    localparam logic [2:0] OPC_ARM_ONE    = 3'd1;
    localparam logic [2:0] OPC_ARM_REP    = 3'd2;
    localparam logic [2:0] OPC_CANCEL_ONE = 3'd3;
    localparam logic [2:0] OPC_CANCEL_REP = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_ONE_FIRED = 3'd0;
    localparam logic [2:0] KIND_REP_FIRED = 3'd1;
    localparam logic [2:0] KIND_ARMED     = 3'd2;
    localparam logic [2:0] KIND_FULL      = 3'd3;
    localparam logic [2:0] KIND_CANCELLED = 3'd4;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd5;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;
    localparam int DELAY_W     = 24;
    localparam int TAG_W       = 16;
    localparam int OUT_ID_W    = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARM,
        ST_CSCAN,
        ST_CFIN,
        ST_TDEC,
        ST_TFIRE,
        ST_TFREE,
        ST_TREP,
        ST_FLUSH
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ARM,
        CMD_CSCAN,
        CMD_CFIN,
        CMD_TDEC,
        CMD_TFIRE,
        CMD_TFREE,
        CMD_TREP,
        CMD_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   walk_first;
    } dp_cmd_t;

    typedef struct packed {
        logic emit_ok;
        logic expire_any;
    } dp_stat_t;

endpackage

>>> hw/rtl/ttes_ctrl.sv
module ttes_ctrl #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2:0]       in_op,
    output logic             in_ready,
    input  ttes_pkg::dp_stat_t stat,
    output ttes_pkg::dp_cmd_t  cmd,
    output logic [IDX_W-1:0] ptr
);
    import ttes_pkg::*;

    localparam logic [IDX_W-1:0] PTR_LAST = IDX_W'(SLOTS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             ptr_end;

    assign ptr_end = (ptr_reg == PTR_LAST);
    assign ptr     = ptr_reg;

    // state and walk counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ptr_next = '0;
                if (in_valid)
                begin
                    case (in_op)
                        OPC_TICK:       state_next = ST_TDEC;
                        OPC_ARM_ONE:    state_next = ST_ARM;
                        OPC_ARM_REP:    state_next = ST_ARM;
                        OPC_CANCEL_ONE: state_next = ST_CSCAN;
                        OPC_CANCEL_REP: state_next = ST_CSCAN;
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ARM:
                if (stat.emit_ok)
                    state_next = ST_FLUSH;
            ST_CSCAN:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_end)
                begin
                    ptr_next   = '0;
                    state_next = ST_CFIN;
                end
            end
            ST_CFIN:
                if (stat.emit_ok)
                    state_next = ST_FLUSH;
            ST_TDEC:
                state_next = ST_TFIRE;
            ST_TFIRE:
            begin
                if (!stat.expire_any)
                    state_next = ST_TREP;
                else if (stat.emit_ok)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    if (ptr_end)
                    begin
                        ptr_next   = '0;
                        state_next = ST_TFREE;
                    end
                end
            end
            ST_TFREE:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_end)
                begin
                    ptr_next   = '0;
                    state_next = ST_TREP;
                end
            end
            ST_TREP:
            begin
                if (stat.emit_ok)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    if (ptr_end)
                    begin
                        ptr_next   = '0;
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
                if (stat.emit_ok)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        in_ready       = 1'b0;
        cmd.op         = CMD_NONE;
        cmd.walk_first = (ptr_reg == '0);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = CMD_LOAD;
            end
            ST_ARM:   if (stat.emit_ok) cmd.op = CMD_ARM;
            ST_CSCAN: cmd.op = CMD_CSCAN;
            ST_CFIN:  if (stat.emit_ok) cmd.op = CMD_CFIN;
            ST_TDEC:  cmd.op = CMD_TDEC;
            ST_TFIRE: if (stat.emit_ok && stat.expire_any) cmd.op = CMD_TFIRE;
            ST_TFREE: cmd.op = CMD_TFREE;
            ST_TREP:  if (stat.emit_ok) cmd.op = CMD_TREP;
            ST_FLUSH: if (stat.emit_ok) cmd.op = CMD_FLUSH;
            default:  cmd.op = CMD_NONE;
        endcase
    end

endmodule

>>> hw/rtl/ttes_dp.sv
`include "tick_timer_event_scheduler_assert.svh"

module ttes_dp #(
    parameter int SLOTS    = 16,
    parameter int ID_WIDTH = 16,
    parameter int IDX_W    = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ttes_pkg::dp_cmd_t       cmd,
    input  logic [IDX_W-1:0]        ptr,
    input  logic [2:0]              in_op,
    input  logic [23:0]             in_delay,
    input  logic [15:0]             in_tag,
    input  logic [15:0]             in_cancel,
    input  logic                    out_ready,
    output ttes_pkg::dp_stat_t      stat,
    output logic                    out_valid,
    output logic [2:0]              out_kind,
    output logic [15:0]             out_id,
    output logic [15:0]             out_tag,
    output logic                    out_last
);
    import ttes_pkg::*;

    localparam int CW = (ID_WIDTH > OUT_ID_W) ? ID_WIDTH : OUT_ID_W;
    localparam logic [IDX_W-1:0] RANK_TOP = IDX_W'(SLOTS - 1);

    // slot storage
    logic                busy_reg   [SLOTS];
    logic                expire_reg [SLOTS];
    logic                rep_reg    [SLOTS];
    logic [DELAY_W-1:0]  rem_reg    [SLOTS];
    logic [DELAY_W-1:0]  per_reg    [SLOTS];
    logic [ID_WIDTH-1:0] ident_reg  [SLOTS];
    logic [TAG_W-1:0]    tag_reg    [SLOTS];
    logic [IDX_W-1:0]    rank_reg   [SLOTS];
    logic [ID_WIDTH-1:0] next_ident_reg, next_ident_next;

    // captured item
    logic [2:0]          op_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic [TAG_W-1:0]    atag_reg;
    logic [15:0]         cid_reg;

    // cancel search
    logic                c_found_reg;
    logic [IDX_W-1:0]    c_slot_reg;
    logic [IDX_W-1:0]    c_rank_reg;

    // result staging
    logic [CNT_W-1:0]    cnt_reg;
    logic                pend_valid_reg;
    logic [2:0]          pend_kind_reg;
    logic [15:0]         pend_id_reg;
    logic [15:0]         pend_tag_reg;
    logic                out_valid_reg;
    logic [2:0]          out_kind_reg;
    logic [15:0]         out_id_reg;
    logic [15:0]         out_tag_reg;
    logic                out_last_reg;

    logic                want_rep;
    logic                any_free;
    logic [IDX_W-1:0]    free_idx;
    logic [IDX_W:0]      busy_cnt;
    logic                scan_match;
    logic                scan_take;
    logic                fire_hit;
    logic [IDX_W-1:0]    fire_slot;
    logic [IDX_W-1:0]    rep_rank;
    logic                rep_hit;
    logic [IDX_W-1:0]    rep_slot;
    logic                rep_due;
    logic                free_en;
    logic [IDX_W-1:0]    free_slot;
    logic [IDX_W-1:0]    free_rank;
    logic                emit_req;
    logic                emit_now;
    logic [2:0]          e_kind;
    logic [15:0]         e_id;
    logic [15:0]         e_tag;
    logic                flush_load;
    logic                expire_any;

    assign want_rep = (op_reg == OPC_ARM_REP) || (op_reg == OPC_CANCEL_REP);
    assign rep_rank = RANK_TOP - ptr;

    // slot searches
    always_comb
    begin
        any_free   = 1'b0;
        free_idx   = '0;
        busy_cnt   = '0;
        fire_hit   = 1'b0;
        fire_slot  = '0;
        rep_hit    = 1'b0;
        rep_slot   = '0;
        expire_any = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
            busy_cnt = busy_cnt + (IDX_W+1)'(busy_reg[i]);
            if (expire_reg[i])
                expire_any = 1'b1;
            if (expire_reg[i] && rank_reg[i] == ptr)
            begin
                fire_hit  = 1'b1;
                fire_slot = IDX_W'(i);
            end
            if (busy_reg[i] && rep_reg[i] && rank_reg[i] == rep_rank)
            begin
                rep_hit  = 1'b1;
                rep_slot = IDX_W'(i);
            end
        end
    end

    // cancel scan step
    assign scan_match = busy_reg[ptr] && (rep_reg[ptr] == want_rep)
                        && (CW'(ident_reg[ptr]) == CW'(cid_reg));
    assign scan_take  = scan_match
                        && (cmd.walk_first || !c_found_reg || rank_reg[ptr] < c_rank_reg);
    assign rep_due    = (rem_reg[rep_slot] <= DELAY_W'(1));

    // result and free selection
    always_comb
    begin
        emit_req  = 1'b0;
        e_kind    = KIND_NOT_FOUND;
        e_id      = '0;
        e_tag     = '0;
        free_en   = 1'b0;
        free_slot = '0;
        case (cmd.op)
            CMD_ARM:
            begin
                emit_req = 1'b1;
                if (any_free)
                begin
                    e_kind = KIND_ARMED;
                    e_id   = 16'(CW'(next_ident_reg));
                end
                else
                    e_kind = KIND_FULL;
            end
            CMD_CFIN:
            begin
                emit_req = 1'b1;
                if (c_found_reg)
                begin
                    e_kind    = KIND_CANCELLED;
                    e_id      = 16'(CW'(ident_reg[c_slot_reg]));
                    free_en   = 1'b1;
                    free_slot = c_slot_reg;
                end
            end
            CMD_TFIRE:
            begin
                emit_req = fire_hit;
                e_kind   = KIND_ONE_FIRED;
                e_id     = 16'(CW'(ident_reg[fire_slot]));
                e_tag    = tag_reg[fire_slot];
            end
            CMD_TFREE:
            begin
                free_en   = expire_reg[ptr];
                free_slot = ptr;
            end
            CMD_TREP:
            begin
                emit_req = rep_hit && rep_due;
                e_kind   = KIND_REP_FIRED;
                e_id     = 16'(CW'(ident_reg[rep_slot]));
                e_tag    = tag_reg[rep_slot];
            end
            default:
                emit_req = 1'b0;
        endcase
    end

    assign free_rank  = rank_reg[free_slot];
    assign emit_now   = emit_req && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign flush_load = (cmd.op == CMD_FLUSH) && pend_valid_reg;

    always_comb
    begin
        next_ident_next = next_ident_reg + 1'b1;
        if (next_ident_next == '0)
            next_ident_next = ID_WIDTH'(1);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                busy_reg[i]   <= 1'b0;
                expire_reg[i] <= 1'b0;
            end
            next_ident_reg <= ID_WIDTH'(1);
            c_found_reg    <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.op == CMD_ARM && any_free)
            begin
                busy_reg[free_idx] <= 1'b1;
                next_ident_reg     <= next_ident_next;
            end
            if (free_en)
                busy_reg[free_slot] <= 1'b0;
            if (cmd.op == CMD_TDEC)
                for (int i = 0; i < SLOTS; i++)
                    expire_reg[i] <= busy_reg[i] && !rep_reg[i]
                                     && (rem_reg[i] <= DELAY_W'(1));
            if (cmd.op == CMD_TFREE)
                expire_reg[ptr] <= 1'b0;
            if (cmd.op == CMD_CSCAN)
                c_found_reg <= scan_take || (!cmd.walk_first && c_found_reg);
            if (cmd.op == CMD_LOAD)
                cnt_reg <= '0;
            else if (emit_now)
                cnt_reg <= cnt_reg + 1'b1;
            // pending result moves to the output register
            if ((emit_now && pend_valid_reg) || flush_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (emit_now)
                pend_valid_reg <= 1'b1;
            else if (cmd.op == CMD_FLUSH)
                pend_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LOAD)
        begin
            op_reg    <= in_op;
            delay_reg <= in_delay;
            atag_reg  <= in_tag;
            cid_reg   <= in_cancel;
        end
        if (cmd.op == CMD_ARM && any_free)
        begin
            rep_reg[free_idx]   <= want_rep;
            per_reg[free_idx]   <= delay_reg;
            rem_reg[free_idx]   <= (!want_rep && delay_reg == '0) ? DELAY_W'(1) : delay_reg;
            tag_reg[free_idx]   <= atag_reg;
            ident_reg[free_idx] <= next_ident_reg;
            rank_reg[free_idx]  <= busy_cnt[IDX_W-1:0];
        end
        if (cmd.op == CMD_TDEC)
            for (int i = 0; i < SLOTS; i++)
                if (busy_reg[i] && !rep_reg[i])
                    rem_reg[i] <= (rem_reg[i] <= DELAY_W'(1)) ? '0 : rem_reg[i] - 1'b1;
        if (cmd.op == CMD_TREP && rep_hit)
            rem_reg[rep_slot] <= rep_due ? per_reg[rep_slot] : rem_reg[rep_slot] - 1'b1;
        if (free_en)
            for (int i = 0; i < SLOTS; i++)
                if (busy_reg[i] && rank_reg[i] > free_rank)
                    rank_reg[i] <= rank_reg[i] - 1'b1;
        if (cmd.op == CMD_CSCAN && scan_take)
        begin
            c_slot_reg <= ptr;
            c_rank_reg <= rank_reg[ptr];
        end
        if (emit_now)
        begin
            pend_kind_reg <= e_kind;
            pend_id_reg   <= e_id;
            pend_tag_reg  <= e_tag;
        end
        if ((emit_now && pend_valid_reg) || flush_load)
        begin
            out_kind_reg <= pend_kind_reg;
            out_id_reg   <= pend_id_reg;
            out_tag_reg  <= pend_tag_reg;
            out_last_reg <= flush_load;
        end
    end

    assign stat.emit_ok    = !pend_valid_reg || !out_valid_reg || out_ready;
    assign stat.expire_any = expire_any;
    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_id    = out_id_reg;
    assign out_tag   = out_tag_reg;
    assign out_last  = out_last_reg;

    // a result never overwrites a beat still waiting on the output
    `TTES_ASSERT_NOW(a_emit_room, clk, rst_n, emit_now && pend_valid_reg,
        !out_valid_reg || out_ready)
    // ids are never zero
    `TTES_ASSERT_NOW(a_ident_nz, clk, rst_n, 1'b1, next_ident_reg != '0)
    // flush empties the staging register
    `TTES_ASSERT_NEXT(a_flush_clear, clk, rst_n, cmd.op == CMD_FLUSH, !pend_valid_reg)

endmodule

>>> hw/rtl/tick_timer_event_scheduler.sv
// Tick-driven timer scheduler with a shared pool of SLOTS timer slots.
// Input beats (s_*) carry an operation: tick, arm one-shot, arm repeat,
// cancel one-shot or cancel repeat. Each beat yields zero or more result
// beats on m_*, the final one of each item marked by m_tlast. A tick that
// fires nothing and an unknown operation give no beats.
// One item is handled at a time by a sequencer walking the slots:
//   an arm stores into a free slot, a cancel walks all slots, and a tick
//   walks fire order, freeing and repeat order (only repeat order when no
//   one-shot expires), one slot per cycle unless a held output stalls it.
// s_tready is high whenever no item is in progress; the last result may
// still sit in the output register then, so the next item overlaps it.
// When m_tready is low the sequencer holds at its next result until the
// output register drains; no result is lost.
// Reset frees every slot and sets the next id to 1; no clearing pass.
module tick_timer_event_scheduler #(
    parameter int SLOTS    = 16,
    parameter int ID_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // operation[2:0], delay_ticks[26:3], action_tag[42:27],
                                  // cancel_id[58:43], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // kind[2:0], timer_id[18:3], fired_tag[34:19], zero fill
    output logic        m_tlast
);
    import ttes_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [IDX_W-1:0] ptr;
    logic [2:0]       out_kind;
    logic [15:0]      out_id;
    logic [15:0]      out_tag;

    ttes_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tdata[2:0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .ptr      (ptr)
    );

    ttes_dp #(
        .SLOTS    (SLOTS),
        .ID_WIDTH (ID_WIDTH),
        .IDX_W    (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ptr       (ptr),
        .in_op     (s_tdata[2:0]),
        .in_delay  (s_tdata[26:3]),
        .in_tag    (s_tdata[42:27]),
        .in_cancel (s_tdata[58:43]),
        .out_ready (m_tready),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_kind  (out_kind),
        .out_id    (out_id),
        .out_tag   (out_tag),
        .out_last  (m_tlast)
    );

    assign m_tdata = {5'b0, out_tag, out_id, out_kind};

endmodule

>>> verif/tick_timer_event_scheduler_checker.sv
module tick_timer_event_scheduler_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ttes_pkg::*;

    localparam int NSLOT = 16;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id;
        logic [15:0] tag;
        logic        last;
    } event_t;

    // shadow timer pool
    logic        busy     [NSLOT];
    logic        is_rep   [NSLOT];
    logic [23:0] remain   [NSLOT];
    logic [23:0] period   [NSLOT];
    logic [15:0] ident    [NSLOT];
    logic [15:0] utag     [NSLOT];
    int          rank     [NSLOT];
    logic [15:0] fresh_id;

    event_t due_events[$];
    event_t batch[$];

    assign pending = due_events.size();

    task automatic report(input string what);
        $display("[%0t] error: %s", $realtime, what);
        errors++;
    endtask

    function automatic void add_event(input logic [2:0] k, input logic [15:0] id,
                                      input logic [15:0] tg);
        event_t e;
        if (batch.size() < MAX_RESULTS)
        begin
            e.kind = k;
            e.id   = id;
            e.tag  = tg;
            e.last = 1'b0;
            batch.push_back(e);
        end
    endfunction

    function automatic void release_slot(input int s);
        busy[s] = 1'b0;
        for (int i = 0; i < NSLOT; i++)
            if (busy[i] && rank[i] > rank[s])
                rank[i]--;
    endfunction

    function automatic void arm_timer(input logic rep, input logic [23:0] dly,
                                      input logic [15:0] tg);
        int s;
        int cnt;
        s = -1;
        cnt = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (busy[i])
                cnt++;
            else if (s < 0)
                s = i;
        end
        if (s < 0)
        begin
            add_event(KIND_FULL, '0, '0);
            return;
        end
        rank[s]   = cnt;
        busy[s]   = 1'b1;
        is_rep[s] = rep;
        period[s] = dly;
        remain[s] = (!rep && dly == 0) ? 24'd1 : dly;
        utag[s]   = tg;
        ident[s]  = fresh_id;
        fresh_id  = fresh_id + 16'd1;
        if (fresh_id == 0)
            fresh_id = 16'd1;
        add_event(KIND_ARMED, ident[s], '0);
    endfunction

    function automatic void cancel_timer(input logic rep, input logic [15:0] id);
        int s;
        s = -1;
        for (int i = 0; i < NSLOT; i++)
            if (busy[i] && is_rep[i] == rep && ident[i] == id && (s < 0 || rank[i] < rank[s]))
                s = i;
        if (s < 0)
        begin
            add_event(KIND_NOT_FOUND, '0, '0);
            return;
        end
        release_slot(s);
        add_event(KIND_CANCELLED, ident[s], '0);
    endfunction

    function automatic void advance_tick();
        logic expired [NSLOT];
        // one-shot countdown
        for (int i = 0; i < NSLOT; i++)
        begin
            expired[i] = 1'b0;
            if (busy[i] && !is_rep[i])
            begin
                if (remain[i] <= 1)
                begin
                    expired[i] = 1'b1;
                    remain[i]  = '0;
                end
                else
                    remain[i]--;
            end
        end
        // fire in arming order, then free
        for (int r = 0; r < NSLOT; r++)
            for (int i = 0; i < NSLOT; i++)
                if (expired[i] && rank[i] == r)
                    add_event(KIND_ONE_FIRED, ident[i], utag[i]);
        for (int i = 0; i < NSLOT; i++)
            if (expired[i])
                release_slot(i);
        // repeats, newest first
        for (int r = NSLOT - 1; r >= 0; r--)
            for (int i = 0; i < NSLOT; i++)
                if (busy[i] && is_rep[i] && rank[i] == r)
                begin
                    if (remain[i] <= 1)
                    begin
                        remain[i] = period[i];
                        add_event(KIND_REP_FIRED, ident[i], utag[i]);
                    end
                    else
                        remain[i]--;
                end
    endfunction

    function automatic void predict_item(input logic [63:0] d);
        logic [2:0] op;
        op = d[2:0];
        batch.delete();
        case (op)
            OPC_TICK:       advance_tick();
            OPC_ARM_ONE:    arm_timer(1'b0, d[26:3], d[42:27]);
            OPC_ARM_REP:    arm_timer(1'b1, d[26:3], d[42:27]);
            OPC_CANCEL_ONE: cancel_timer(1'b0, d[58:43]);
            OPC_CANCEL_REP: cancel_timer(1'b1, d[58:43]);
            default: ;
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            due_events.push_back(batch[k]);
    endfunction

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        event_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                busy[i] = 1'b0;
                rank[i] = 0;
            end
            fresh_id = 16'd1;
            due_events.delete();
            errors = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_events.size() == 0)
                    report($sformatf("unexpected beat kind=%0d id=%0d", m_tdata[2:0],
                                     m_tdata[18:3]));
                else
                begin
                    want = due_events.pop_front();
                    if (m_tdata[2:0] !== want.kind)
                        report($sformatf("kind %0d, want %0d", m_tdata[2:0], want.kind));
                    if (m_tdata[18:3] !== want.id)
                        report($sformatf("timer_id %0d, want %0d", m_tdata[18:3], want.id));
                    if (m_tdata[34:19] !== want.tag)
                        report($sformatf("fired_tag %h, want %h", m_tdata[34:19], want.tag));
                    if (m_tlast !== want.last)
                        report($sformatf("tlast %b, want %b", m_tlast, want.last));
                end
            end
            if (s_tvalid && s_tready)
                predict_item(s_tdata);
        end
    end

endmodule

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ttes_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          errors;
    int          pending;

    logic        s_beat;
    logic        m_beat;
    int          quiet_cycles = 0;
    int          out_wait = 0;
    bit          no_gaps = 0;
    int          arms_sent = 0;

    always #2 clk = ~clk;

    tick_timer_event_scheduler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    tick_timer_event_scheduler_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    // handshakes seen mid-cycle, taken at the next rising edge; watchdog
    always @(negedge clk)
    begin
        s_beat = s_tvalid && s_tready;
        m_beat = m_tvalid && m_tready;
        if (s_beat || m_beat || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tick_timer_event_scheduler: mismatch");
            $finish;
        end
    end

    // result side back-pressure: fresh wait drawn per beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_beat)
                out_wait = no_gaps ? 0 : $urandom_range(0, 7);
            if (out_wait > 0)
            begin
                m_tready <= 1'b0;
                out_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [23:0] dly,
                             input logic [15:0] tg, input logic [15:0] id);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, id, tg, dly, op};
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        if (op == OPC_ARM_ONE || op == OPC_ARM_REP)
            arms_sent++;
    endtask

    function automatic logic [15:0] likely_id();
        int lo;
        lo = (arms_sent > 24) ? arms_sent - 24 : 1;
        return 16'($urandom_range(lo, arms_sent + 2));
    endfunction

    initial
    begin
        int pick;
        logic [23:0] dly;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every operation, special cases
        send_item(OPC_ARM_ONE, 24'd0, 16'hFFFF, 16'hFFFF);
        send_item(OPC_ARM_ONE, 24'hFFFFFF, 16'h0000, 16'h0000);
        send_item(OPC_ARM_REP, 24'd0, 16'hA5A5, 16'h0);
        send_item(OPC_ARM_REP, 24'd2, 16'h5A5A, 16'h0);
        send_item(OPC_TICK, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OPC_TICK, '0, '0, '0);
        send_item(OPC_TICK, '0, '0, '0);
        send_item(OPC_CANCEL_ONE, '0, '0, 16'd0);
        send_item(OPC_CANCEL_ONE, '0, '0, 16'd2);
        send_item(OPC_CANCEL_REP, '0, '0, 16'd3);
        send_item(OPC_CANCEL_REP, '0, '0, 16'd3);
        send_item(OPC_CANCEL_ONE, '0, '0, 16'hFFFF);
        send_item(3'd5, 24'd1, 16'd1, 16'd1);
        send_item(3'd7, '1, '1, '1);
        send_item(OPC_TICK, '0, '0, '0);
        // fill the pool to overflow
        for (int k = 0; k < 17; k++)
            send_item(OPC_ARM_ONE, 24'd1, 16'($urandom), '0);
        send_item(OPC_ARM_REP, 24'd1, 16'h1234, '0);
        // every one-shot fires on one tick
        send_item(OPC_TICK, '0, '0, '0);
        send_item(OPC_TICK, '0, '0, '0);

        // random traffic, mostly short delays so timers keep expiring
        for (int n = 0; n < 185; n++)
        begin
            if (n % 50 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            dly  = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6));
            if (pick < 36)
                send_item(OPC_TICK, 24'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 60)
                send_item(OPC_ARM_ONE, dly, 16'($urandom), 16'($urandom));
            else if (pick < 70)
                send_item(OPC_ARM_REP, dly, 16'($urandom), 16'($urandom));
            else if (pick < 82)
                send_item(OPC_CANCEL_ONE, dly, 16'($urandom), likely_id());
            else if (pick < 91)
                send_item(OPC_CANCEL_REP, dly, 16'($urandom), likely_id());
            else if (pick < 97)
                send_item(3'($urandom_range(OPC_CANCEL_ONE, OPC_CANCEL_REP)), dly,
                          16'($urandom), 16'($urandom));
            else
                send_item(3'($urandom_range(5, 7)), 24'($urandom), 16'($urandom),
                          16'($urandom));
        end
        s_tvalid <= 1'b0;

        // drain, then allow for a tick still walking the slots
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tick_timer_event_scheduler: match");
        else
            $display("tick_timer_event_scheduler: mismatch");
        $finish;
    end

endmodule

>>> tick_timer_event_scheduler.f
+incdir+hw/rtl
hw/rtl/ttes_pkg.sv
hw/rtl/ttes_ctrl.sv
hw/rtl/ttes_dp.sv
hw/rtl/tick_timer_event_scheduler.sv
verif/tick_timer_event_scheduler_checker.sv
verif/tb.sv
